@@ hdl/bfbl_pkg.sv @@
`timescale 1ns / 1ps
package bfbl_pkg;
  localparam int MAX_VERTICES_DEF = 4096;
  localparam int MAX_EDGES_DEF = 16384;
  localparam int TILE_BITS = 64;
  localparam int LEVEL_W = 13;
  localparam logic [LEVEL_W-1:0] LEVEL_MASK = '1;

  localparam logic [1:0] CMD_LOAD_OFFSET = 2'd0;
  localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
  localparam logic [1:0] CMD_RUN = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic CFG_TILE_COUNT = 1'b0;
  localparam logic CFG_SOURCE = 1'b1;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [13:0] item_index;
    logic [14:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic result_kind;
    logic [12:0] level;
    logic range_error;
  } out_word_t;
endpackage

@@ hdl/bfbl_queue.sv @@
`timescale 1ns / 1ps
module bfbl_queue
  import bfbl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output in_word_t out_word
);
  in_word_t slots [2];
  logic [1:0] count;
  logic rd_ptr;
  logic wr_ptr;
  logic push;
  logic pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_word = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_word;
    end
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ hdl/bfbl_engine.sv @@
`timescale 1ns / 1ps
module bfbl_engine
  import bfbl_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_word_t  cmd,
  input  logic [6:0] tile_count,
  input  logic [11:0] source_vertex,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res
);
  localparam int TILES = MAX_VERTICES / TILE_BITS;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int OW = $clog2(MAX_EDGES + 1);
  localparam int OAW = $clog2(MAX_VERTICES + 1);
  localparam int CW = VW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_SEED = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_SCANW = 4'd5;
  localparam logic [3:0] S_SCANC = 4'd6;
  localparam logic [3:0] S_OFF0 = 4'd7;
  localparam logic [3:0] S_OFF1 = 4'd8;
  localparam logic [3:0] S_OFF2 = 4'd9;
  localparam logic [3:0] S_EDGE = 4'd10;
  localparam logic [3:0] S_EDGEW = 4'd11;
  localparam logic [3:0] S_LVW = 4'd12;
  localparam logic [3:0] S_LVC = 4'd13;
  localparam logic [3:0] S_RDW = 4'd14;
  localparam logic [3:0] S_RDD = 4'd15;

  // a vertex is visited once its level is nonzero; the frontier holds the
  // vertices whose level equals the level counter
  logic [OW-1:0] offset_mem [MAX_VERTICES + 1];
  logic [VW:0] edge_mem [MAX_EDGES];
  logic [LEVEL_W-1:0] level_mem [MAX_VERTICES];

  logic [3:0] state;
  logic [LEVEL_W-1:0] level_counter;
  logic [LEVEL_W-1:0] deepest;
  logic [CW-1:0] nverts;
  logic [VW-1:0] vtx;
  logic [OW-1:0] edge_ptr;
  logic [OW-1:0] edge_end;
  logic [OW-1:0] off_q;
  logic [OAW-1:0] off_addr;
  logic [EW-1:0] edge_addr;
  logic [VW:0] edge_q;
  logic [VW-1:0] lvl_addr;
  logic [LEVEL_W-1:0] lvl_q;
  logic any_next;
  logic [VW-1:0] clr_idx;
  out_word_t res_reg;
  logic [6:0] tc_eff;
  logic [OW-1:0] end_clip;
  logic last_vtx;
  logic edge_new;

  assign cmd_ready = (state == S_IDLE) && !res_valid;
  assign res = res_reg;
  assign tc_eff = (tile_count == 7'd0) ? 7'd1 :
                  ({25'd0, tile_count} > TILES) ? 7'(TILES) : tile_count;
  assign end_clip = (off_q > OW'(MAX_EDGES)) ? OW'(MAX_EDGES) : off_q;
  assign last_vtx = ({1'b0, vtx} == nverts - 1'b1);
  // top bit of an edge entry marks a target beyond every vertex
  assign edge_new = !edge_q[VW] && ({1'b0, edge_q[VW-1:0]} < nverts) && (lvl_q == '0);

  always_ff @(posedge clk) begin
    off_q <= offset_mem[off_addr];
    edge_q <= edge_mem[edge_addr];
    lvl_q <= level_mem[lvl_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      clr_idx <= '0;
      res_valid <= 1'b0;
      level_counter <= LEVEL_W'(1);
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          level_mem[clr_idx] <= '0;
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == VW'(MAX_VERTICES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            nverts <= CW'({tc_eff, 6'd0});
            unique case (cmd.command)
              CMD_LOAD_OFFSET: begin
                if ({18'd0, cmd.item_index} <= MAX_VERTICES)
                  offset_mem[OAW'(cmd.item_index)] <= OW'(cmd.item_value);
              end
              CMD_LOAD_EDGE: begin
                if ({18'd0, cmd.item_index} < MAX_EDGES)
                  edge_mem[EW'(cmd.item_index)] <=
                    {({17'd0, cmd.item_value} >= MAX_VERTICES), VW'(cmd.item_value)};
              end
              CMD_RUN: begin
                clr_idx <= '0;
                state <= S_CLEAR;
              end
              default: begin
                lvl_addr <= VW'(cmd.item_index);
                res_reg.result_kind <= KIND_READ;
                if ({18'd0, cmd.item_index} < {19'd0, tc_eff, 6'd0}) begin
                  res_reg.range_error <= 1'b0;
                  state <= S_RDW;
                end else begin
                  res_reg.range_error <= 1'b1;
                  res_reg.level <= '0;
                  res_valid <= 1'b1;
                end
              end
            endcase
          end
        end
        S_RDW: state <= S_RDD;
        S_RDD: begin
          res_reg.level <= lvl_q;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_CLEAR: begin
          level_mem[clr_idx] <= '0;
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == VW'(MAX_VERTICES - 1)) begin
            level_counter <= LEVEL_W'(1);
            deepest <= '0;
            if ({20'd0, source_vertex} < {19'd0, nverts}) begin
              state <= S_SEED;
            end else begin
              res_reg <= '{KIND_RUN, '0, 1'b0};
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_SEED: begin
          level_mem[VW'(source_vertex)] <= LEVEL_W'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          deepest <= level_counter;
          any_next <= 1'b0;
          vtx <= '0;
          lvl_addr <= '0;
          state <= S_SCANW;
        end
        S_SCANW: state <= S_SCANC;
        S_SCANC: begin
          if (lvl_q == level_counter) begin
            off_addr <= OAW'(vtx);
            state <= S_OFF0;
          end else if (last_vtx) begin
            level_counter <= level_counter + 1'b1;
            if (any_next) begin
              state <= S_SCAN;
            end else begin
              res_reg <= '{KIND_RUN, deepest, 1'b0};
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            vtx <= vtx + 1'b1;
            lvl_addr <= vtx + 1'b1;
            state <= S_SCANW;
          end
        end
        S_OFF0: begin
          off_addr <= OAW'(vtx) + 1'b1;
          state <= S_OFF1;
        end
        S_OFF1: begin
          edge_ptr <= off_q;
          state <= S_OFF2;
        end
        S_OFF2: begin
          edge_end <= end_clip;
          edge_addr <= EW'(edge_ptr);
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (edge_ptr >= edge_end) begin
            if (last_vtx) begin
              level_counter <= level_counter + 1'b1;
              if (any_next) begin
                state <= S_SCAN;
              end else begin
                res_reg <= '{KIND_RUN, deepest, 1'b0};
                res_valid <= 1'b1;
                state <= S_IDLE;
              end
            end else begin
              vtx <= vtx + 1'b1;
              lvl_addr <= vtx + 1'b1;
              state <= S_SCANW;
            end
          end else begin
            state <= S_EDGEW;
          end
        end
        S_EDGEW: begin
          lvl_addr <= edge_q[VW-1:0];
          state <= S_LVW;
        end
        S_LVW: state <= S_LVC;
        S_LVC: begin
          if (edge_new) begin
            level_mem[edge_q[VW-1:0]] <= level_counter + 1'b1;
            any_next <= 1'b1;
          end
          edge_ptr <= edge_ptr + 1'b1;
          edge_addr <= EW'(edge_ptr + 1'b1);
          state <= S_EDGE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/bitmap_frontier_bfs_levels.sv @@
`timescale 1ns / 1ps
// After reset a pass over the level store clears it; words wait in the 2-deep queue.
// Load words: one per cycle while the engine idles, applied at the edge it takes them.
// Read words: the result is set in state S_RDD after S_RDW; out of range, on taking the word.
// Run words: clear the level store, seed the source if it is in range (else level 0),
// then scan each level's frontier and its edges. No word is taken while a result waits.
// Synchronous active-high rst returns control state and the config registers to reset values.
module bitmap_frontier_bfs_levels
  import bfbl_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [11:0] cfg_data
);
  logic [6:0] tile_count;
  logic [11:0] source_vertex;
  logic q_valid;
  logic q_ready;
  in_word_t q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count <= 7'd1;
      source_vertex <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TILE_COUNT: tile_count <= cfg_data[6:0];
        default: source_vertex <= cfg_data;
      endcase
    end
  end

  bfbl_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
  );

  bfbl_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_engine (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_word),
    .tile_count(tile_count), .source_vertex(source_vertex),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_word)
  );
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import bfbl_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic [1:0] cmd;
    int idx;
    int val;
    bit typed;
    int lvl;
    bit err;
  } row_t;

  typedef struct {
    bit typed;
    out_word_t word;
  } row_tag_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [11:0] cfg_data = '0;

  // predictor state
  int offs [0:MAX_VERTICES_DEF];
  int edges [0:MAX_EDGES_DEF-1];
  logic [12:0] levels [0:MAX_VERTICES_DEF-1];
  logic [63:0] seen [0:63];
  logic [63:0] cur_front [0:63];
  logic [63:0] next_front [0:63];
  logic [6:0] tile_reg = 7'd1;
  logic [11:0] src_reg = 12'd0;

  out_word_t pending_results[$];
  row_tag_t row_tags[$];
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int searches = 0;
  int lookups = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int graph_base, graph_k;
  bit graph_ok = 1'b0;

  bitmap_frontier_bfs_levels dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int vertex_count();
    int t;
    t = tile_reg;
    if (t == 0) t = 1;
    if (t > 64) t = 64;
    return t * TILE_BITS;
  endfunction

  function automatic logic [12:0] bfs_depth();
    int tiles, nv, v, s, e, to;
    logic [12:0] ctr, deepest;
    bit empty;
    tiles = vertex_count() / TILE_BITS;
    nv = tiles * TILE_BITS;
    deepest = '0;
    ctr = 13'd1;
    for (int t = 0; t < 64; t++) begin
      seen[t] = '0;
      cur_front[t] = '0;
      next_front[t] = '0;
    end
    for (int i = 0; i < MAX_VERTICES_DEF; i++) levels[i] = '0;
    if (src_reg >= nv) return '0;
    next_front[src_reg / 64][src_reg % 64] = 1'b1;
    do begin
      for (int t = 0; t < tiles; t++) begin
        cur_front[t] = next_front[t];
        if (next_front[t] != 0) begin
          seen[t] |= next_front[t];
          for (int b = 0; b < 64; b++)
            if (next_front[t][b]) levels[t * 64 + b] = ctr;
          next_front[t] = '0;
        end
      end
      deepest = ctr;
      empty = 1'b1;
      for (int t = 0; t < tiles; t++) begin
        for (int b = 0; b < 64; b++) begin
          if (!cur_front[t][b]) continue;
          v = t * 64 + b;
          s = offs[v];
          e = offs[v + 1];
          if (e > MAX_EDGES_DEF) e = MAX_EDGES_DEF;
          for (int i = s; i < e; i++) begin
            to = edges[i];
            if (to >= nv) continue;
            if (seen[to / 64][to % 64]) continue;
            next_front[to / 64][to % 64] = 1'b1;
            empty = 1'b0;
          end
        end
      end
      ctr = ctr + 13'd1;
    end while (!empty);
    return deepest;
  endfunction

  function automatic void apply_word(in_word_t w);
    out_word_t r;
    row_tag_t tag;
    tag = row_tags.pop_front();
    r = '0;
    case (w.command)
      CMD_LOAD_OFFSET: if (w.item_index <= MAX_VERTICES_DEF) offs[w.item_index] = w.item_value;
      CMD_LOAD_EDGE: if (w.item_index < MAX_EDGES_DEF) edges[w.item_index] = w.item_value;
      CMD_RUN: begin
        r.result_kind = KIND_RUN;
        r.level = bfs_depth();
        pending_results.push_back(tag.typed ? tag.word : r);
      end
      default: begin
        r.result_kind = KIND_READ;
        if (w.item_index < vertex_count()) r.level = levels[w.item_index];
        else r.range_error = 1'b1;
        pending_results.push_back(tag.typed ? tag.word : r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (!rst) begin
      if (in_valid && in_ready) apply_word(in_word);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TILE_COUNT) tile_reg = cfg_data[6:0];
        else src_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind %0d level %0d err %0d", $time,
                   out_word.result_kind, out_word.level, out_word.range_error);
        end else begin
          out_word_t x;
          x = pending_results.pop_front();
          if (x.result_kind == KIND_RUN) searches++;
          else lookups++;
          if (x !== out_word) begin
            errors++;
            $display("%0t: mismatch exp kind %0d level %0d err %0d, got %0d %0d %0d",
                     $time, x.result_kind, x.level, x.range_error,
                     out_word.result_kind, out_word.level, out_word.range_error);
          end
        end
      end
    end
  end

  task automatic send(logic [1:0] cmd, int idx, int val, bit typed = 0,
                      out_word_t exp_w = '0);
    row_tag_t tag;
    tag.typed = typed;
    tag.word = exp_w;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    row_tags.push_back(tag);
    in_valid <= 1'b1;
    in_word <= '{command: cmd, item_index: idx[13:0], item_value: val[14:0]};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[11:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic build_graph(int kmax);
    int nv, k, base, pos, deg, tgt;
    nv = vertex_count();
    k = $urandom_range(2, kmax);
    if (src_reg < nv) begin
      base = src_reg - $urandom_range(0, (k - 1 < src_reg) ? k - 1 : src_reg);
      if (base + k > nv) base = nv - k;
    end else begin
      base = $urandom_range(0, nv - k);
    end
    pos = $urandom_range(0, MAX_EDGES_DEF - 4 * k - 1);
    for (int i = 0; i < k; i++) begin
      send(CMD_LOAD_OFFSET, base + i, pos);
      deg = $urandom_range(0, 3);
      for (int d = 0; d < deg; d++) begin
        if ($urandom_range(99) < 90 || nv == MAX_VERTICES_DEF)
          tgt = base + $urandom_range(0, k - 1);
        else
          tgt = $urandom_range(nv, 16384);
        send(CMD_LOAD_EDGE, pos, tgt);
        pos++;
      end
    end
    send(CMD_LOAD_OFFSET, base + k, pos);
    graph_base = base;
    graph_k = k;
    graph_ok = 1'b1;
  endtask

  task automatic noise_words();
    int n, nv, pick;
    nv = vertex_count();
    n = $urandom_range(2, 6);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: send(CMD_LOAD_OFFSET, $urandom_range(MAX_VERTICES_DEF + 1, 16383),
                $urandom_range(0, 16384));
        1: if (nv + 1 < MAX_VERTICES_DEF)
             send(CMD_LOAD_OFFSET, $urandom_range(nv + 1, MAX_VERTICES_DEF), 0);
        // targets stay beyond the current vertex count, so these edges reach no vertex
        2: send(CMD_LOAD_EDGE, $urandom_range(0, 16383), $urandom_range(nv, 16384));
        3: send(CMD_READ, $urandom_range(0, 16383), $urandom_range(0, 16384));
        default: if (nv <= 256 && graph_ok) send(CMD_RUN, $urandom_range(0, 16383), 0);
      endcase
    end
  endtask

  function automatic out_word_t mk(logic kind, int lvl, logic err);
    out_word_t w;
    w.result_kind = kind;
    w.level = lvl[12:0];
    w.range_error = err;
    return w;
  endfunction

  initial begin
    row_t rows[$];
    int tiles_cfg [NUM_PHASES];
    int src_cfg [NUM_PHASES];
    int quota, kmax, nreads;

    tiles_cfg = '{1, 64, 0, 127, 2, 5};
    src_cfg = '{0, 4095, 37, 200, 200, 300};
    for (int i = 0; i <= MAX_VERTICES_DEF; i++) offs[i] = 0;
    for (int i = 0; i < MAX_EDGES_DEF; i++) edges[i] = 0;
    for (int i = 0; i < MAX_VERTICES_DEF; i++) levels[i] = '0;

    rows = '{
      '{CMD_READ, 0, 0, 1, 0, 0},
      '{CMD_READ, 64, 0, 1, 0, 1},
      '{CMD_READ, 16383, 32767, 1, 0, 1},
      '{CMD_RUN, 0, 0, 1, 1, 0},
      '{CMD_READ, 0, 0, 1, 1, 0},
      '{CMD_READ, 63, 0, 1, 0, 0},
      '{CMD_LOAD_OFFSET, 4097, 16384, 0, 0, 0},
      '{CMD_LOAD_OFFSET, 16383, 0, 0, 0, 0},
      '{CMD_LOAD_EDGE, 16383, 16384, 0, 0, 0},
      '{CMD_LOAD_EDGE, 0, 1, 0, 0, 0},
      '{CMD_LOAD_EDGE, 1, 16384, 0, 0, 0},
      '{CMD_LOAD_EDGE, 2, 0, 0, 0, 0},
      '{CMD_LOAD_OFFSET, 0, 0, 0, 0, 0},
      '{CMD_LOAD_OFFSET, 1, 2, 0, 0, 0},
      '{CMD_LOAD_OFFSET, 2, 3, 0, 0, 0},
      '{CMD_RUN, 0, 0, 1, 2, 0},
      '{CMD_READ, 1, 0, 1, 2, 0},
      '{CMD_READ, 2, 0, 1, 0, 0},
      '{CMD_READ, 0, 0, 1, 1, 0},
      '{CMD_RUN, 16383, 0, 0, 0, 0},
      '{CMD_READ, 5, 0, 0, 0, 0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // the first tile starts with no edges so the early runs stay defined
    for (int i = 0; i <= TILE_BITS; i++) send(CMD_LOAD_OFFSET, i, 0);

    foreach (rows[i])
      send(rows[i].cmd, rows[i].idx, rows[i].val, rows[i].typed,
           mk(rows[i].cmd == CMD_READ, rows[i].lvl, rows[i].err));
    drain();
    repeat (16) @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_TILE_COUNT, tiles_cfg[p]);
      write_reg(CFG_SOURCE, src_cfg[p]);
      graph_ok = 1'b0;
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 69; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 69; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      kmax = (vertex_count() > 512) ? 8 : 24;
      quota = words_sent + 215;
      while (words_sent < quota) begin
        if ($urandom_range(99) < 80) begin
          build_graph(kmax);
          send(CMD_RUN, $urandom_range(0, 16383), $urandom_range(0, 16384));
          if ($urandom_range(99) < 20) drain();
          nreads = $urandom_range(3, 8);
          for (int r = 0; r < nreads; r++) begin
            if ($urandom_range(99) < 80)
              send(CMD_READ, graph_base + $urandom_range(0, graph_k - 1), 0);
            else
              send(CMD_READ, $urandom_range(0, 16383), 0);
          end
        end else begin
          noise_words();
        end
      end
      drain();
      repeat (16) @(posedge clk);
    end

    send_idle = 0;
    recv_stall = 0;
    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d words over %0d register settings and all idle mixes;", words_sent,
             NUM_PHASES);
    $display("checked %0d search results and %0d level reads.", searches, lookups);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
